FILE: design/conformal_pvalue_combiner_core_macros.svh
// Assertion macros for the conformal p-value combiner checker.
`ifndef CONFORMAL_PVALUE_COMBINER_CORE_MACROS_SVH
`define CONFORMAL_PVALUE_COMBINER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define CPC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpc assertion failed");

// Next-cycle implication, clocked on clk, off during reset
`define CPC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpc assertion failed");

`endif

FILE: design/cpc_pkg.sv
package cpc_pkg;

  localparam int NUM_PATHS        = 4;
  localparam int SCORE_WIDTH      = 32;
  localparam int BUFFER_DEPTH_DEF = 4096;
  localparam int LANE_W           = $clog2(NUM_PATHS);
  localparam int KW               = 3;
  localparam int AF_W             = 32;
  localparam int WC_W             = 13;
  localparam int CFG_W            = 32;
  localparam int DIV_W            = 36;
  localparam int DVS_W            = 33;
  localparam int EV_SHIFT         = 16;
  localparam int CMB_SHIFT        = 48;

  localparam logic [KW-1:0]   DEF_PATH_COUNT = 3'd3;
  localparam logic [AF_W-1:0] DEF_ALPHA      = 32'd4294967;
  localparam logic [WC_W-1:0] DEF_WINDOW     = 13'd4096;

  // Configuration register indexes
  localparam logic [1:0] CFG_PATH_COUNT = 2'd0;
  localparam logic [1:0] CFG_ALPHA      = 2'd1;
  localparam logic [1:0] CFG_WINDOW     = 2'd2;

  typedef enum logic [1:0] {
    KIND_OBSERVE = 2'd0,
    KIND_BONF    = 2'd1,
    KIND_EVALUE  = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_RSTART,
    S_RWAIT,
    S_IDLE,
    S_OBS,
    S_SCAN,
    S_BMUL,
    S_BCMP,
    S_EDIV,
    S_EWAIT,
    S_EMUL,
    S_ECMP
  } state_t;

  typedef struct packed {
    logic              en;
    logic [LANE_W-1:0] lane;
  } mem_wr_t;

  // Order-preserving unsigned key of a signed score
  function automatic logic [SCORE_WIDTH-1:0] score_key(input logic [SCORE_WIDTH-1:0] s);
    score_key = s ^ {1'b1, {(SCORE_WIDTH-1){1'b0}}};
  endfunction

endpackage

FILE: design/cpc_divider.sv
module cpc_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cpc_pkg::DIV_W-1:0]   dividend,
  input  logic [cpc_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [cpc_pkg::DIV_W-1:0]   quotient
);

  localparam int CW = $clog2(cpc_pkg::DIV_W + 1);

  logic [cpc_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [cpc_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [cpc_pkg::DVS_W-1:0] dvs_r;
  logic [CW-1:0]             cnt_r;
  logic                      done_r;
  logic [cpc_pkg::DVS_W:0]   trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[cpc_pkg::DIV_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = cpc_pkg::DVS_W'(trial - {1'b0, dvs_r});
      quo_nxt = {quo_r[cpc_pkg::DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[cpc_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[cpc_pkg::DIV_W-2:0], 1'b0};
    end
  end

  // Load on start, otherwise step until the count runs out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(cpc_pkg::DIV_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CW'(1);
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: design/cpc_score_mem.sv
module cpc_score_mem #(
  parameter int DEPTH = cpc_pkg::BUFFER_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                           clk,
  input  cpc_pkg::mem_wr_t                               wr,
  input  logic [AW-1:0]                                  wr_addr,
  input  logic [cpc_pkg::SCORE_WIDTH-1:0]                wr_data,
  input  logic                                           rd_en,
  input  logic [AW-1:0]                                  rd_addr,
  output logic [cpc_pkg::NUM_PATHS-1:0][cpc_pkg::SCORE_WIDTH-1:0] rd_data
);

  // One row per ring slot, one lane per path
  logic [cpc_pkg::NUM_PATHS-1:0][cpc_pkg::SCORE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr][wr.lane] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/conformal_pvalue_combiner_core.sv
// Conformal p-value combiner. Keeps a ring of calibration scores per path in
// one shared memory whose row holds one slot of every ring. Observe items
// (kind 0) write one score per used path and give no result. A decision
// (kind 1 Bonferroni, kind 2 e-value) scans the rings, all paths in the same
// memory read, up to the largest fill among the used paths; then Bonferroni
// multiplies and compares per path, the e-value path divides per path in the
// shared iterative divider, then multiplies and compares. A decision with no
// used path or on a disarmed block answers in the cycle after start. The
// result is shown on out_valid for one cycle and cannot be held off; busy
// stays high until the next item can be taken. After reset and after every
// write to a known configuration register the block recomputes its arming
// with busy high and empties all rings; the memory itself needs no clearing.
module conformal_pvalue_combiner_core #(
  parameter int BUFFER_DEPTH = cpc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_kind,
  input  logic [2:0]                     in_score_count,
  input  logic signed [31:0]             in_score_0,
  input  logic signed [31:0]             in_score_1,
  input  logic signed [31:0]             in_score_2,
  input  logic signed [31:0]             in_score_3,
  output logic                           out_valid,
  output logic                           out_alarm,
  output logic                           out_disarmed,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [cpc_pkg::CFG_W-1:0]      cfg_data
);

  localparam int NP    = cpc_pkg::NUM_PATHS;
  localparam int SW    = cpc_pkg::SCORE_WIDTH;
  localparam int LW    = cpc_pkg::LANE_W;
  localparam int KW    = cpc_pkg::KW;
  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int FW    = AW + 1;
  localparam int CW    = (FW > cpc_pkg::WC_W) ? FW : cpc_pkg::WC_W;
  localparam int M1W   = KW + FW;
  localparam int M2W   = cpc_pkg::AF_W + FW;
  localparam int BW    = M1W + 32;
  localparam int SUMW  = FW + cpc_pkg::EV_SHIFT + LW;
  localparam int PW    = SUMW + cpc_pkg::AF_W;
  localparam int FLW   = M2W + KW;

  cpc_pkg::state_t state_r, state_nxt;

  // Configuration and arming
  logic [KW-1:0]               path_count_r;
  logic [cpc_pkg::AF_W-1:0]    alpha_r;
  logic [cpc_pkg::WC_W-1:0]    window_r;
  logic [cpc_pkg::AF_W-1:0]    eff_alpha_r;
  logic [KW-1:0]               eff_k_r;
  logic                        armed_r;
  logic [FW-1:0]               cap_r;

  // Ring bookkeeping
  logic [AW-1:0]               wp_r   [NP];
  logic [FW-1:0]               fill_r [NP];

  // Item context
  cpc_pkg::kind_t              kind_r;
  logic [KW-1:0]               k_r;
  logic [SW-1:0]               qkey_r [NP];

  // Scan and combine
  logic [FW-1:0]               addr_r;
  logic                        rd_v_r;
  logic [FW-1:0]               rd_idx_r;
  logic [FW-1:0]               ge_r [NP];
  logic [LW-1:0]               lane_r;
  logic                        alarm_acc_r;
  logic [M1W-1:0]              m1_r;
  logic [M2W-1:0]              m2_r;
  logic [SUMW-1:0]             sum_r;
  logic [PW-1:0]               prod_r;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_alarm_r, out_alarm_nxt;
  logic                        out_disarmed_r, out_disarmed_nxt;

  // Memory and divider hookup
  cpc_pkg::mem_wr_t            mem_wr;
  logic [AW-1:0]               mem_wr_addr;
  logic [SW-1:0]               mem_wr_data;
  logic                        mem_rd_en;
  logic [NP-1:0][SW-1:0]       mem_rd_data;
  logic                        div_start;
  logic [cpc_pkg::DIV_W-1:0]   div_a;
  logic [cpc_pkg::DVS_W-1:0]   div_b;
  logic                        div_done;
  logic [cpc_pkg::DIV_W-1:0]   div_q;

  // Shared combinational terms
  logic [cpc_pkg::AF_W-1:0]    af_eff;
  logic                        k_bad;
  logic                        cfg_hit;
  logic                        accept;
  logic [KW-1:0]               k_in;
  logic                        use_ok;
  logic [FW-1:0]               fill_max;
  logic                        issue;
  logic                        lane_last;
  logic [FW-1:0]               fill_l;
  logic [FW-1:0]               ge_l;
  logic                        bonf_hit;
  logic                        need_ok;
  logic                        floor_ok;
  logic [CW-1:0]               cap_calc;
  logic [AW-1:0]               wp_use;
  logic [FW-1:0]               wp_inc;
  logic [SW-1:0]               in_key [NP];

  cpc_score_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (addr_r[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  cpc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_key[0] = cpc_pkg::score_key(in_score_0);
  assign in_key[1] = cpc_pkg::score_key(in_score_1);
  assign in_key[2] = cpc_pkg::score_key(in_score_2);
  assign in_key[3] = cpc_pkg::score_key(in_score_3);

  assign af_eff  = (alpha_r == '0) ? cpc_pkg::DEF_ALPHA : alpha_r;
  assign k_bad   = (path_count_r == '0) || (path_count_r > KW'(NP));
  assign cfg_hit = cfg_we && (cfg_index == cpc_pkg::CFG_PATH_COUNT ||
                              cfg_index == cpc_pkg::CFG_ALPHA ||
                              cfg_index == cpc_pkg::CFG_WINDOW);
  assign accept  = start && (state_r == cpc_pkg::S_IDLE);
  assign k_in    = (in_score_count < eff_k_r) ? in_score_count : eff_k_r;
  assign use_ok  = armed_r && (k_in != '0);

  // Largest fill among the used paths bounds the scan
  always_comb begin
    fill_max = '0;
    for (int l = 0; l < NP; l++) begin
      if (KW'(l) < k_r && fill_r[l] > fill_max) begin
        fill_max = fill_r[l];
      end
    end
  end

  assign issue     = (state_r == cpc_pkg::S_SCAN) && (addr_r < fill_max);
  assign lane_last = (KW'(lane_r) + KW'(1)) == k_r;
  assign fill_l    = fill_r[lane_r];
  assign ge_l      = ge_r[lane_r];
  assign bonf_hit  = {m1_r, 32'b0} <= BW'(m2_r);
  assign need_ok   = div_q <= cpc_pkg::DIV_W'(BUFFER_DEPTH);
  assign floor_ok  = FLW'(m2_r) > FLW'({path_count_r, 32'b0});

  // Capacity: raise the request to the need, clip to the depth
  always_comb begin
    cap_calc = CW'(window_r);
    if (cap_calc < CW'(div_q[FW-1:0])) begin
      cap_calc = CW'(div_q[FW-1:0]);
    end
    if (cap_calc > CW'(BUFFER_DEPTH)) begin
      cap_calc = CW'(BUFFER_DEPTH);
    end
  end

  // Ring slot for the lane being written
  assign wp_use = (FW'(wp_r[lane_r]) >= cap_r) ? '0 : wp_r[lane_r];
  assign wp_inc = FW'(wp_use) + FW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpc_pkg::S_RSTART: state_nxt = k_bad ? cpc_pkg::S_IDLE : cpc_pkg::S_RWAIT;
      cpc_pkg::S_RWAIT:  if (div_done) state_nxt = cpc_pkg::S_IDLE;
      cpc_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cpc_pkg::kind_t'(in_kind))
            cpc_pkg::KIND_OBSERVE: if (use_ok) state_nxt = cpc_pkg::S_OBS;
            cpc_pkg::KIND_BONF,
            cpc_pkg::KIND_EVALUE:  if (use_ok) state_nxt = cpc_pkg::S_SCAN;
            default:               state_nxt = cpc_pkg::S_IDLE;
          endcase
        end
      end
      cpc_pkg::S_OBS:    if (lane_last) state_nxt = cpc_pkg::S_IDLE;
      cpc_pkg::S_SCAN: begin
        if (!issue && !rd_v_r) begin
          state_nxt = (kind_r == cpc_pkg::KIND_BONF) ? cpc_pkg::S_BMUL : cpc_pkg::S_EDIV;
        end
      end
      cpc_pkg::S_BMUL:   state_nxt = cpc_pkg::S_BCMP;
      cpc_pkg::S_BCMP:   state_nxt = lane_last ? cpc_pkg::S_IDLE : cpc_pkg::S_BMUL;
      cpc_pkg::S_EDIV:   state_nxt = cpc_pkg::S_EWAIT;
      cpc_pkg::S_EWAIT: begin
        if (div_done) state_nxt = lane_last ? cpc_pkg::S_EMUL : cpc_pkg::S_EDIV;
      end
      cpc_pkg::S_EMUL:   state_nxt = cpc_pkg::S_ECMP;
      cpc_pkg::S_ECMP:   state_nxt = cpc_pkg::S_IDLE;
      default:           state_nxt = cpc_pkg::S_IDLE;
    endcase
    if (cfg_hit) begin
      state_nxt = cpc_pkg::S_RSTART;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    div_start        = 1'b0;
    div_a            = '0;
    div_b            = '0;
    mem_wr           = '0;
    mem_wr_addr      = wp_use;
    mem_wr_data      = qkey_r[lane_r];
    mem_rd_en        = 1'b0;
    out_valid_nxt    = 1'b0;
    out_alarm_nxt    = 1'b0;
    out_disarmed_nxt = 1'b0;
    unique case (state_r)
      cpc_pkg::S_RSTART: begin
        div_start = !k_bad;
        div_a     = cpc_pkg::DIV_W'({path_count_r, 32'b0}) +
                    cpc_pkg::DIV_W'(af_eff) - cpc_pkg::DIV_W'(1);
        div_b     = cpc_pkg::DVS_W'(af_eff);
      end
      cpc_pkg::S_IDLE: begin
        if (accept && !use_ok &&
            (in_kind == cpc_pkg::KIND_BONF || in_kind == cpc_pkg::KIND_EVALUE)) begin
          out_valid_nxt    = 1'b1;
          out_disarmed_nxt = !armed_r;
        end
      end
      cpc_pkg::S_OBS: begin
        mem_wr.en   = 1'b1;
        mem_wr.lane = lane_r;
      end
      cpc_pkg::S_SCAN: mem_rd_en = issue;
      cpc_pkg::S_BCMP: begin
        out_valid_nxt = lane_last;
        out_alarm_nxt = alarm_acc_r || bonf_hit;
      end
      cpc_pkg::S_EDIV: begin
        div_start = 1'b1;
        div_a     = cpc_pkg::DIV_W'({fill_l + FW'(1), {cpc_pkg::EV_SHIFT{1'b0}}});
        div_b     = cpc_pkg::DVS_W'(ge_l + FW'(1));
      end
      cpc_pkg::S_ECMP: begin
        out_valid_nxt = 1'b1;
        out_alarm_nxt = prod_r >= PW'({eff_k_r, {cpc_pkg::CMB_SHIFT{1'b0}}});
      end
      default: ;
    endcase
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= cpc_pkg::S_RSTART;
      path_count_r   <= cpc_pkg::DEF_PATH_COUNT;
      alpha_r        <= cpc_pkg::DEF_ALPHA;
      window_r       <= cpc_pkg::DEF_WINDOW;
      armed_r        <= 1'b0;
      eff_k_r        <= '0;
      rd_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int l = 0; l < NP; l++) begin
        wp_r[l]   <= '0;
        fill_r[l] <= '0;
      end
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      out_alarm_r    <= out_alarm_nxt;
      out_disarmed_r <= out_disarmed_nxt;
      rd_v_r         <= issue;
      rd_idx_r       <= addr_r;
      unique case (state_r)
        cpc_pkg::S_RSTART: begin
          eff_alpha_r <= af_eff;
          armed_r     <= 1'b0;
          eff_k_r     <= '0;
          cap_r       <= '0;
          m2_r        <= M2W'(af_eff) * M2W'(BUFFER_DEPTH + 1);
        end
        cpc_pkg::S_RWAIT: begin
          if (div_done && need_ok && floor_ok) begin
            armed_r <= 1'b1;
            eff_k_r <= path_count_r;
            cap_r   <= FW'(cap_calc);
          end
        end
        cpc_pkg::S_IDLE: begin
          if (accept) begin
            kind_r      <= cpc_pkg::kind_t'(in_kind);
            k_r         <= k_in;
            addr_r      <= '0;
            lane_r      <= '0;
            alarm_acc_r <= 1'b0;
            sum_r       <= '0;
            for (int l = 0; l < NP; l++) begin
              qkey_r[l] <= in_key[l];
              ge_r[l]   <= '0;
            end
          end
        end
        cpc_pkg::S_OBS: begin
          // Advance the ring head and grow the fill up to capacity
          wp_r[lane_r] <= (wp_inc >= cap_r) ? '0 : wp_inc[AW-1:0];
          if (fill_r[lane_r] < cap_r) begin
            fill_r[lane_r] <= fill_r[lane_r] + FW'(1);
          end
          lane_r <= lane_r + LW'(1);
        end
        cpc_pkg::S_SCAN: begin
          if (issue) begin
            addr_r <= addr_r + FW'(1);
          end
          // Count stored scores at or above the query, per path
          if (rd_v_r) begin
            for (int l = 0; l < NP; l++) begin
              if (KW'(l) < k_r && rd_idx_r < fill_r[l] && mem_rd_data[l] >= qkey_r[l]) begin
                ge_r[l] <= ge_r[l] + FW'(1);
              end
            end
          end
        end
        cpc_pkg::S_BMUL: begin
          m1_r <= M1W'(eff_k_r) * M1W'(ge_l + FW'(1));
          m2_r <= M2W'(eff_alpha_r) * M2W'(fill_l + FW'(1));
        end
        cpc_pkg::S_BCMP: begin
          alarm_acc_r <= alarm_acc_r || bonf_hit;
          lane_r      <= lane_r + LW'(1);
        end
        cpc_pkg::S_EWAIT: begin
          if (div_done) begin
            sum_r  <= sum_r + SUMW'(div_q[FW+cpc_pkg::EV_SHIFT-1:0]);
            lane_r <= lane_r + LW'(1);
          end
        end
        cpc_pkg::S_EMUL: prod_r <= PW'(sum_r) * PW'(eff_alpha_r);
        default: ;
      endcase
      // Writes to a known register empty every ring and rearm
      if (cfg_we) begin
        case (cfg_index)
          cpc_pkg::CFG_PATH_COUNT: path_count_r <= cfg_data[KW-1:0];
          cpc_pkg::CFG_ALPHA:      alpha_r      <= cfg_data[cpc_pkg::AF_W-1:0];
          cpc_pkg::CFG_WINDOW:     window_r     <= cfg_data[cpc_pkg::WC_W-1:0];
          default: ;
        endcase
        if (cfg_hit) begin
          for (int l = 0; l < NP; l++) begin
            wp_r[l]   <= '0;
            fill_r[l] <= '0;
          end
        end
      end
    end
  end

  assign busy         = (state_r != cpc_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_alarm    = out_alarm_r;
  assign out_disarmed = out_disarmed_r;

endmodule

FILE: design/cpc_checker.sv
`include "conformal_pvalue_combiner_core_macros.svh"

module cpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       cfg_we,
  input logic [1:0] cfg_index,
  input logic       out_valid,
  input logic       out_alarm,
  input logic       out_disarmed
);

  logic cfg_hit;

  // Writes to a known register
  assign cfg_hit = cfg_we && (cfg_index == cpc_pkg::CFG_PATH_COUNT ||
                              cfg_index == cpc_pkg::CFG_ALPHA ||
                              cfg_index == cpc_pkg::CFG_WINDOW);

  // A disarmed block never raises an alarm
  `CPC_ASSERT_IMP(a_disarm_quiet, out_valid && out_disarmed, !out_alarm)

  // A write to a known register always starts the rearm sequence
  `CPC_ASSERT_NXT(a_cfg_rearm, cfg_hit, busy)

  // A result only follows work in progress or a fresh item
  `CPC_ASSERT_IMP(a_result_cause, out_valid, $past(busy || start))

endmodule

bind conformal_pvalue_combiner_core cpc_checker u_cpc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index),
  .out_valid    (out_valid),
  .out_alarm    (out_alarm),
  .out_disarmed (out_disarmed)
);
